[rtl/shfc_pkg.sv]
// Package for the single/half float converter.
// Holds the command codes and format constants; no dependencies.
package shfc_pkg;

    typedef enum logic {
        CMD_S2H = 1'b0,
        CMD_H2S = 1'b1
    } t_cmd;

    localparam logic [14:0] HALF_MAX_MAG = 15'h7fff;
    localparam logic [30:0] SINGLE_QNAN  = 31'h7FC00000;

endpackage

[rtl/single_half_float_converter_top.sv]
// Single/half float converter, top level.
// o_valid follows start through the r_v1 and r_v2 registers. Throughput: one request per cycle.
// busy is always low; the result is held one cycle and cannot be stalled.
// Synchronous active-low reset clears the valid pipeline.
// Depends on shfc_pkg and shfc_s2h.
module single_half_float_converter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_command,
    input  logic [31:0] i_operand_bits,
    output logic        o_valid,
    output logic [31:0] o_result_bits
);

    logic        r_v1;
    logic        r_cmd;
    logic [31:0] r_op;
    logic        r_v2;
    logic [31:0] r_res;
    logic [31:0] n_res;
    logic [15:0] s2h;
    logic [15:0] h;
    logic [3:0]  p;
    logic [9:0]  mn;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= start;
            r_v2 <= r_v1;
        end
        r_cmd <= i_command;
        r_op  <= i_operand_bits;
        r_res <= n_res;
    end

    shfc_s2h u_s2h (
        .i_x (r_op),
        .o_h (s2h)
    );

    assign h = r_op[15:0];

    // Position of the leading one of a half subnormal mantissa.
    always_comb begin
        p = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (h[i]) begin
                p = 4'(i);
            end
        end
        mn = h[9:0] << (4'd10 - p);
    end

    always_comb begin
        if (r_cmd == shfc_pkg::CMD_S2H) begin
            n_res = {16'd0, s2h};
        end else if (h[14:0] == 15'h7fff) begin
            n_res = {h[15], shfc_pkg::SINGLE_QNAN};
        end else if (h[14:10] == 5'd0) begin
            if (h[9:0] == 10'd0) begin
                n_res = {h[15], 31'd0};
            end else begin
                n_res = {h[15], 8'(p) + 8'd103, mn, 13'd0};
            end
        end else begin
            n_res = {h[15], {3'd0, h[14:10]} + 8'd112, h[9:0], 13'd0};
        end
    end

    assign o_valid       = r_v2;
    assign o_result_bits = r_res;

endmodule

[rtl/shfc_s2h.sv]
// Single to half conversion datapath, purely combinational.
// Depends on shfc_pkg.
module shfc_s2h (
    input  logic [31:0] i_x,
    output logic [15:0] o_h
);

    logic        sign;
    logic [7:0]  e;
    logic [22:0] f;
    logic [4:0]  lz;
    logic [23:0] sig;
    logic [23:0] fsh;
    logic [23:0] rsh;
    logic [23:0] mask;
    logic [23:0] rem;
    logic [23:0] half;
    logic [11:0] q;
    logic [11:0] m;
    logic signed [9:0] ex;
    logic signed [9:0] he;
    logic signed [9:0] sh;
    logic        up;

    assign sign = i_x[31];
    assign e    = i_x[30:23];
    assign f    = i_x[22:0];

    // Leading-zero count of the subnormal fraction.
    always_comb begin
        lz = 5'd23;
        for (int i = 0; i < 23; i++) begin
            if (f[i]) begin
                lz = 5'(22 - i);
            end
        end
    end

    assign fsh = {1'b0, f} << lz;

    always_comb begin
        if (e == 8'd0) begin
            sig = {fsh[22:0], 1'b0};
            ex  = -10'sd127 - 10'(signed'({5'd0, lz}));
        end else begin
            sig = {1'b1, f};
            ex  = 10'(signed'({2'b00, e})) - 10'sd127;
        end
        he = ex + 10'sd15;
        sh = (he >= 10'sd1) ? 10'sd13 : (-ex - 10'sd1);
    end

    always_comb begin
        rsh  = 24'd0;
        mask = 24'd0;
        half = 24'd0;
        if (sh <= 10'sd24) begin
            rsh  = sig >> sh[4:0];
            mask = (24'd1 << sh[4:0]) - 24'd1;
            half = 24'd1 << (sh[4:0] - 5'd1);
        end
        rem = sig & mask;
        up  = (rem > half) || ((rem == half) && rsh[0]);
        q   = rsh[11:0] + {11'd0, up};
    end

    always_comb begin
        m = q;
        if (e == 8'hff) begin
            o_h = {sign, shfc_pkg::HALF_MAX_MAG};
        end else if (e == 8'd0 && f == 23'd0) begin
            o_h = {sign, 15'd0};
        end else if (he >= 10'sd1) begin
            if (q == 12'd2048) begin
                if (he + 10'sd1 > 10'sd31) begin
                    o_h = {sign, shfc_pkg::HALF_MAX_MAG};
                end else begin
                    o_h = {sign, 5'(he + 10'sd1), 10'd0};
                end
            end else if (he > 10'sd31) begin
                o_h = {sign, shfc_pkg::HALF_MAX_MAG};
            end else begin
                o_h = {sign, he[4:0], m[9:0]};
            end
        end else if (sh > 10'sd24) begin
            o_h = {sign, 15'd0};
        end else begin
            o_h = {sign, q[10:0] == 11'd0 ? 15'd0 : {4'd0, q[10:0]}};
        end
    end

endmodule

[rtl/shfc_checker.sv]
// Port-level checker for the single/half float converter.
// Depends on shfc_pkg; bound to single_half_float_converter_top.
module shfc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_command,
    input logic [31:0] i_operand_bits,
    input logic        o_valid,
    input logic [31:0] o_result_bits
);

    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> ##1 o_valid) else $error("request lost");

    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !start |=> ##1 !o_valid) else $error("spurious result");

    a_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && i_command == shfc_pkg::CMD_S2H |=> ##1 o_result_bits[31:16] == 16'd0)
        else $error("half result upper bits set");

    a_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && i_command == shfc_pkg::CMD_H2S && i_operand_bits[14:0] == 15'h7fff
        |=> ##1 o_result_bits[30:0] == shfc_pkg::SINGLE_QNAN)
        else $error("NaN decode wrong");

endmodule

bind single_half_float_converter_top shfc_checker u_shfc_checker (.*);
